[sv/bcd_pkg.sv]
// Shared types, constants and helpers for the bitcrush decimator.
// No dependencies; imported by bcd_mul, bcd_ctrl and the top level, and named by scope in bcd_checker.
package bcd_pkg;

    localparam int FIELD_W  = 32;   // width of each sample field on the streams
    localparam int GAIN_W   = 25;   // widest gain (24 bit unsigned) plus a sign bit
    localparam int HELD_W   = 17;   // crushed value, -32768..32768
    localparam int FRAC_W   = 16;   // 16.16 gain fraction
    localparam int IDX_W    = 3;
    localparam int CFG_W    = 24;

    localparam logic [IDX_W-1:0] REG_DRIVE_GAIN = 3'd0;
    localparam logic [IDX_W-1:0] REG_WET_GAIN   = 3'd1;
    localparam logic [IDX_W-1:0] REG_DRY_GAIN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_KEPT_BITS  = 3'd3;
    localparam logic [IDX_W-1:0] REG_HOLD_LEN   = 3'd4;

    // products issued to the shared multiplier, in sequence order
    typedef enum logic [2:0] {
        OP_DRV_L,
        OP_DRV_R,
        OP_DRY_L,
        OP_WET_L,
        OP_DRY_R,
        OP_WET_R
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // sequencer to datapath
    typedef struct packed {
        logic take;      // latch the input item
        logic issue;     // start a product this cycle
        op_t  op;
        logic load_out;  // move accumulators to the output register
    } ctl_t;

    // tag that travels alongside a registered product
    typedef struct packed {
        logic valid;
        op_t  op;
    } tag_t;

    // mask that clears the low 16-kept bits; kept is clamped to 1..16
    function automatic logic [HELD_W-1:0] crush_mask(input logic [4:0] kept);
        logic [4:0]        kb;
        logic [3:0]        sh;
        logic [HELD_W-1:0] ones;
        kb = kept;
        if (kb < 5'd1)
        begin
            kb = 5'd1;
        end
        if (kb > 5'd16)
        begin
            kb = 5'd16;
        end
        sh   = 4'(5'd16 - kb);
        ones = (HELD_W'(1) << sh) - HELD_W'(1);
        return ~ones;
    endfunction

endpackage

[sv/bcd_mul.sv]
// Shared signed multiplier with a registered product and op tag.
// Depends on bcd_pkg.
module bcd_mul #(
    parameter int A_W = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              issue,
    input  bcd_pkg::op_t                      op,
    input  logic signed [A_W-1:0]             a,
    input  logic signed [bcd_pkg::GAIN_W-1:0] b,
    output bcd_pkg::tag_t                     tag,
    output logic signed [A_W+bcd_pkg::GAIN_W-1:0] prod
);
    import bcd_pkg::*;

    tag_t                           tag_reg;
    logic signed [A_W+GAIN_W-1:0]   prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '{valid: 1'b0, op: OP_DRV_L};
        end
        else
        begin
            tag_reg.valid <= issue;
            if (issue)
            begin
                tag_reg.op <= op;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= a * b;
        end
    end

    assign tag  = tag_reg;
    assign prod = prod_reg;

endmodule

[sv/bcd_ctrl.sv]
// Sequencer: hold countdown and product schedule for one frame.
// Depends on bcd_pkg.
module bcd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          out_free,
    input  logic [15:0]   hold_length,
    output logic          in_ready,
    output bcd_pkg::ctl_t ctl
);
    import bcd_pkg::*;

    state_t      state_reg, state_next;
    op_t         op_reg, op_next;
    logic [15:0] hold_count_reg, hold_count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_DRV_L;
            hold_count_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            hold_count_reg <= hold_count_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        hold_count_next = hold_count_reg;
        in_ready        = 1'b0;
        ctl             = '{take: 1'b0, issue: 1'b0, op: op_reg, load_out: 1'b0};
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.take   = 1'b1;
                    state_next = ST_RUN;
                    if (hold_count_reg == 16'd0)
                    begin
                        // capture frame; zero length behaves as one
                        hold_count_next = (hold_length == 16'd0) ? 16'd0
                                                                 : hold_length - 16'd1;
                        op_next = OP_DRV_L;
                    end
                    else
                    begin
                        hold_count_next = hold_count_reg - 16'd1;
                        op_next         = OP_DRY_L;
                    end
                end
            end
            ST_RUN:
            begin
                ctl.issue = 1'b1;
                if (op_reg == OP_WET_R)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    op_next = op_t'(op_reg + 3'd1);
                end
            end
            ST_DRAIN:
            begin
                // last product is folded in this cycle
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/bitcrush_decimator.sv]
// Top level of the stereo bitcrusher / sample-rate reducer with dry/wet mix.
// Depends on bcd_pkg, bcd_ctrl, bcd_mul.
//
// One stereo frame goes in per input item and one mixed frame comes out.
// All six products (two drive, two dry, two wet) run through one shared
// registered multiplier, one product per cycle. A capture frame (hold
// counter at zero) issues all six; a held frame skips the two drive
// products. The input is ready again in the cycle after the result loads,
// while that result may still sit in the output register. There is no
// clearing pass after reset. Configuration is written through cfg_wr_en/
// cfg_index/cfg_data; the user must write it only while no frame is in
// flight, as the block itself does not enforce this.
module bitcrush_decimator #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // wet_left, wet_right, dry_left, dry_right (32 bits each, signed)
    input  logic [4*bcd_pkg::FIELD_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_left, out_right (32 bits each, signed)
    output logic [2*bcd_pkg::FIELD_W-1:0]    m_axis_tdata,
    input  logic                             cfg_wr_en,
    input  logic [bcd_pkg::IDX_W-1:0]        cfg_index,
    input  logic [bcd_pkg::CFG_W-1:0]        cfg_data
);
    import bcd_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int P_W  = SW + GAIN_W;
    localparam int T_W  = P_W - FRAC_W;

    localparam logic signed [T_W-1:0] CLAMP_HI = T_W'(32768);
    localparam logic signed [T_W-1:0] CLAMP_LO = -T_W'(32768);

    logic [23:0] drive_gain_reg;
    logic [19:0] wet_gain_reg;
    logic [16:0] dry_gain_reg;
    logic [4:0]  kept_bits_reg;
    logic [15:0] hold_length_reg;

    logic signed [SW-1:0]     wet_l_reg, wet_r_reg, dry_l_reg, dry_r_reg;
    logic signed [HELD_W-1:0] held_l_reg, held_r_reg;
    logic [SW-1:0]            acc_l_reg, acc_r_reg;

    logic                     m_valid_reg;
    logic [2*FIELD_W-1:0]     m_data_reg;

    ctl_t                     ctl;
    tag_t                     tag;
    logic signed [P_W-1:0]    prod;
    logic signed [SW-1:0]     mul_a;
    logic signed [GAIN_W-1:0] mul_b;
    logic signed [T_W-1:0]    term;
    logic signed [HELD_W-1:0] crushed;
    logic                     out_free;

    assign out_free = !m_valid_reg || m_axis_tready;

    bcd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .out_free    (out_free),
        .hold_length (hold_length_reg),
        .in_ready    (s_axis_tready),
        .ctl         (ctl)
    );

    bcd_mul #(
        .A_W (SW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (ctl.issue),
        .op    (ctl.op),
        .a     (mul_a),
        .b     (mul_b),
        .tag   (tag),
        .prod  (prod)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_gain_reg  <= 24'd65536;
            wet_gain_reg    <= 20'd65536;
            dry_gain_reg    <= 17'd0;
            kept_bits_reg   <= 5'd16;
            hold_length_reg <= 16'd1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DRIVE_GAIN: drive_gain_reg  <= cfg_data[23:0];
                REG_WET_GAIN:   wet_gain_reg    <= cfg_data[19:0];
                REG_DRY_GAIN:   dry_gain_reg    <= cfg_data[16:0];
                REG_KEPT_BITS:  kept_bits_reg   <= cfg_data[4:0];
                REG_HOLD_LEN:   hold_length_reg <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    // input samples, low SAMPLE_WIDTH bits of each lane
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            wet_l_reg <= s_axis_tdata[0*FIELD_W +: SW];
            wet_r_reg <= s_axis_tdata[1*FIELD_W +: SW];
            dry_l_reg <= s_axis_tdata[2*FIELD_W +: SW];
            dry_r_reg <= s_axis_tdata[3*FIELD_W +: SW];
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        case (ctl.op)
            OP_DRV_L:
            begin
                mul_a = wet_l_reg;
                mul_b = GAIN_W'(drive_gain_reg);
            end
            OP_DRV_R:
            begin
                mul_a = wet_r_reg;
                mul_b = GAIN_W'(drive_gain_reg);
            end
            OP_DRY_L:
            begin
                mul_a = dry_l_reg;
                mul_b = GAIN_W'(dry_gain_reg);
            end
            OP_WET_L:
            begin
                mul_a = SW'(held_l_reg);
                mul_b = GAIN_W'(wet_gain_reg);
            end
            OP_DRY_R:
            begin
                mul_a = dry_r_reg;
                mul_b = GAIN_W'(dry_gain_reg);
            end
            OP_WET_R:
            begin
                mul_a = SW'(held_r_reg);
                mul_b = GAIN_W'(wet_gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // floor of product / 2^16, then clamp and crush for the drive path
    assign term = T_W'(prod >>> FRAC_W);

    always_comb
    begin
        logic signed [HELD_W-1:0] clamped;
        if (term > CLAMP_HI)
        begin
            clamped = HELD_W'(32768);
        end
        else if (term < CLAMP_LO)
        begin
            clamped = -HELD_W'(32768);
        end
        else
        begin
            clamped = term[HELD_W-1:0];
        end
        // clearing low bits of a two's complement value is a floor
        crushed = clamped & crush_mask(kept_bits_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_l_reg <= '0;
            held_r_reg <= '0;
        end
        else if (tag.valid)
        begin
            case (tag.op)
                OP_DRV_L: held_l_reg <= crushed;
                OP_DRV_R: held_r_reg <= crushed;
                default:  ;
            endcase
        end
    end

    // mix accumulators wrap at SAMPLE_WIDTH bits
    always_ff @(posedge clk)
    begin
        if (tag.valid)
        begin
            case (tag.op)
                OP_DRY_L: acc_l_reg <= term[SW-1:0];
                OP_WET_L: acc_l_reg <= acc_l_reg + term[SW-1:0];
                OP_DRY_R: acc_r_reg <= term[SW-1:0];
                OP_WET_R: acc_r_reg <= acc_r_reg + term[SW-1:0];
                default:  ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (ctl.load_out)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            m_data_reg <= {FIELD_W'($signed(acc_r_reg)), FIELD_W'($signed(acc_l_reg))};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

[sv/bcd_checker.sv]
// Port-level checks for bitcrush_decimator, attached by bind.
// Depends on bcd_pkg and the top level's ports.
module bcd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [2*bcd_pkg::FIELD_W-1:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    // a taken frame keeps the input busy after it is accepted
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=>
            !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready
            ##1 !s_axis_tready ##1 !s_axis_tready)
        else $error("input taken while a frame is in flight");

    // a new result only appears as a frame finishes
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("output item without a frame in flight");

endmodule

bind bitcrush_decimator bcd_checker u_bcd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
